// File: design/thph_pkg.sv
// thph_pkg: shared types, constants and the entry ordering function
// for the two-key host priority heap; no dependencies
package thph_pkg;

    localparam int HEAP_DEPTH_DEF   = 256;
    localparam int HOST_ID_BITS_DEF = 10;

    localparam int UF_W   = 17;
    localparam int LF_W   = 26;
    localparam int PROD_W = 26;

    typedef enum logic [1:0] {
        MODE_REPORT   = 2'd0,
        MODE_WITHDRAW = 2'd1,
        MODE_SUGGEST  = 2'd2,
        MODE_REMOVE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_NONE  = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_SPARE = 2'd3
    } status_t;

    localparam logic [2:0] REG_CONSOLE_W = 3'd0;
    localparam logic [2:0] REG_TTY_W     = 3'd1;
    localparam logic [2:0] REG_LOAD_W1   = 3'd2;
    localparam logic [2:0] REG_LOAD_W5   = 3'd3;
    localparam logic [2:0] REG_LOAD_W15  = 3'd4;

    typedef struct packed {
        logic [7:0] console_weight;
        logic [7:0] tty_weight;
        logic [7:0] load_weight_1;
        logic [7:0] load_weight_5;
        logic [7:0] load_weight_15;
    } weights_t;

    // true when entry a may stay above entry b (user factor, then load factor)
    function automatic logic entry_le(input logic signed [UF_W-1:0] ua,
                                      input logic [LF_W-1:0] la,
                                      input logic signed [UF_W-1:0] ub,
                                      input logic [LF_W-1:0] lb);
        return (ua < ub) || ((ua == ub) && (la <= lb));
    endfunction

endpackage

// File: design/thph_factor.sv
// thph_factor: user and load factor of one report, built on one shared
// 9x17 signed multiplier; depends on thph_pkg
module thph_factor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  thph_pkg::weights_t                  weights,
    input  logic                                console_in_use,
    input  logic [7:0]                          unique_users,
    input  logic [15:0]                         load_avg_1,
    input  logic [15:0]                         load_avg_5,
    input  logic [15:0]                         load_avg_15,
    output logic                                done,
    output logic signed [thph_pkg::UF_W-1:0]    user_factor,
    output logic [thph_pkg::LF_W-1:0]           load_factor
);

    logic [2:0]                               step_reg, step_next;
    logic signed [thph_pkg::PROD_W-1:0]       prod_reg;
    logic signed [thph_pkg::UF_W-1:0]         uf_reg;
    logic [thph_pkg::LF_W-1:0]                lf_reg;
    logic [7:0]                               mul_a;
    logic signed [16:0]                       mul_b;
    logic signed [16:0]                       user_term;
    logic signed [thph_pkg::PROD_W-1:0]       uf_sum;

    assign user_term = $signed(17'({9'b0, unique_users}) - 17'(console_in_use));
    assign uf_sum    = $signed(26'(weights.console_weight)) + prod_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        case (step_reg)
            3'd1:
            begin
                mul_a = weights.tty_weight;
                mul_b = user_term;
            end
            3'd2:
            begin
                mul_a = weights.load_weight_1;
                mul_b = $signed({1'b0, load_avg_1});
            end
            3'd3:
            begin
                mul_a = weights.load_weight_5;
                mul_b = $signed({1'b0, load_avg_5});
            end
            default:
            begin
                mul_a = weights.load_weight_15;
                mul_b = $signed({1'b0, load_avg_15});
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (start)
            step_next = 3'd1;
        else if (step_reg == 3'd6)
            step_next = 3'd0;
        else if (step_reg != 3'd0)
            step_next = step_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= 3'd0;
        else
            step_reg <= step_next;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed({1'b0, mul_a}) * mul_b;
        case (step_reg)
            3'd2:    uf_reg <= console_in_use ? uf_sum[thph_pkg::UF_W-1:0]
                                              : prod_reg[thph_pkg::UF_W-1:0];
            3'd3:    lf_reg <= prod_reg[thph_pkg::LF_W-1:0];
            3'd4:    lf_reg <= lf_reg + prod_reg[thph_pkg::LF_W-1:0];
            3'd5:    lf_reg <= lf_reg + prod_reg[thph_pkg::LF_W-1:0];
            default: lf_reg <= lf_reg;
        endcase
    end

    assign done        = (step_reg == 3'd6);
    assign user_factor = uf_reg;
    assign load_factor = lf_reg;

endmodule

// File: design/two_key_host_priority_heap.sv
// two_key_host_priority_heap: top level with sequencer, heap memory and
// host position map; depends on thph_pkg and thph_factor
//
// Usage: items enter on the s_ stream (tuser = mode, tdata = host and report
// fields), one result per item leaves on the m_ stream (tuser = status,
// tdata = granted entry and entry count). Weights must be written on the cfg
// channel, which is always ready, only while the block is idle; the block does not enforce this.
// After reset the position map is swept to zero, one host a cycle, across all
// 2**HOST_ID_BITS hosts (1024 by default); s_tready stays low meanwhile.
// One item at a time, s_tready high only in idle: a remove looks up the entry
// and loads the hole and the last entry, then walks the hole down a level at a
// time for the sift-down (two child reads through the single heap read port,
// then the move) and moves the last entry up a level at a time for the
// bubble-up; a report adds the multiplier steps and an insert bubble. The
// heap memory port walks one level at a time. The result is held in an output
// register; an item that finishes while the previous result is still held
// waits with s_tready low until that result is taken.
module two_key_host_priority_heap #(
    parameter int HEAP_DEPTH   = thph_pkg::HEAP_DEPTH_DEF,
    parameter int HOST_ID_BITS = thph_pkg::HOST_ID_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // host_id[9:0], console_in_use[10], unique_users[18:11], load_avg_1[34:19],
    // load_avg_5[50:35], load_avg_15[66:51], position[75:67], zero fill
    input  logic [79:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // granted_host[9:0], granted_user_factor[26:10], granted_load_factor[52:27],
    // entry_count[61:53], zero fill
    output logic [63:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int HB    = HOST_ID_BITS;
    localparam int PW    = $clog2(HEAP_DEPTH + 1);
    localparam int HOSTS = 1 << HB;
    localparam int AW    = (PW > 9) ? PW : 9;

    typedef struct packed {
        logic [HB-1:0]                        host;
        logic signed [thph_pkg::UF_W-1:0]     uf;
        logic [thph_pkg::LF_W-1:0]            lf;
    } entry_t;

    typedef enum logic [15:0] {
        S_CLEAR = 16'h0001,
        S_IDLE  = 16'h0002,
        S_LOOK  = 16'h0004,
        S_CHK   = 16'h0008,
        S_MUL   = 16'h0010,
        S_RM0   = 16'h0020,
        S_RM1   = 16'h0040,
        S_RM2   = 16'h0080,
        S_SD0   = 16'h0100,
        S_SD1   = 16'h0200,
        S_SD2   = 16'h0400,
        S_UP0   = 16'h0800,
        S_UP1   = 16'h1000,
        S_RMEND = 16'h2000,
        S_INS   = 16'h4000,
        S_FIN   = 16'h8000
    } state_t;

    state_t                 state_reg, state_next;
    logic [HB-1:0]          clr_reg, clr_next;
    logic [PW-1:0]          count_reg, count_next;
    logic [1:0]             mode_reg;
    logic [HB-1:0]          host_reg;
    logic                   console_reg;
    logic [7:0]             users_reg;
    logic [15:0]            l1_reg, l5_reg, l15_reg;
    logic [8:0]             pos_in_reg;
    logic [PW-1:0]          mine_reg, mine_next;
    logic signed [thph_pkg::UF_W-1:0] top_uf_reg, top_uf_next;
    logic [PW-1:0]          at_reg, at_next;
    logic [PW-1:0]          p_reg, p_next;
    logic [PW:0]            c_reg, c_next;
    entry_t                 got_reg, got_next;
    entry_t                 carry_reg, carry_next;
    entry_t                 left_reg, left_next;
    logic                   have_last_reg, have_last_next;
    logic                   ins_after_reg, ins_after_next;
    logic                   bubble_ins_reg, bubble_ins_next;
    logic                   granted_reg, granted_next;
    thph_pkg::status_t      status_reg, status_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [63:0]            m_tdata_reg, m_tdata_next;
    logic [1:0]             m_tuser_reg, m_tuser_next;
    thph_pkg::weights_t     weights_reg;

    entry_t                 heap_mem [0:HEAP_DEPTH];
    logic [PW-1:0]          pos_mem [0:HOSTS-1];
    logic                   hw_en;
    logic [PW-1:0]          hw_addr;
    entry_t                 hw_data;
    logic [PW-1:0]          hr_addr;
    entry_t                 hr_q;
    logic                   pw_en;
    logic [HB-1:0]          pw_addr;
    logic [PW-1:0]          pw_data;
    logic [HB-1:0]          pr_addr;
    logic [PW-1:0]          pr_q;

    logic                   accept;
    logic [31:0]            in_host32;
    logic                   fac_start;
    logic                   fac_done;
    logic signed [thph_pkg::UF_W-1:0] fac_uf;
    logic [thph_pkg::LF_W-1:0]        fac_lf;

    logic [PW-1:0]          mine_c;
    logic [PW:0]            n_ext;
    logic [PW:0]            c_c;
    logic [PW:0]            c_plus;
    logic                   sel_mine;
    logic [AW-1:0]          at_c;
    logic                   pick_left;
    logic [31:0]            got_host32;
    logic [31:0]            count32;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_host32 = 32'(s_tdata[9:0]);

    assign mine_c   = (pr_q > count_reg) ? '0 : pr_q;
    assign n_ext    = {1'b0, count_reg};
    assign c_c      = {p_reg, 1'b0};
    assign c_plus   = c_reg + (PW+1)'(1);
    assign sel_mine = (mode_reg == thph_pkg::MODE_SUGGEST) && (mine_reg != '0) &&
                      ($signed({hr_q.uf[thph_pkg::UF_W-1], hr_q.uf}) <=
                       $signed({top_uf_reg[thph_pkg::UF_W-1], top_uf_reg}) + 18'sd1);
    assign at_c     = sel_mine ? AW'(mine_reg) : AW'(pos_in_reg);
    assign pick_left = thph_pkg::entry_le(left_reg.uf, left_reg.lf, hr_q.uf, hr_q.lf);
    assign got_host32 = 32'(got_reg.host);
    assign count32    = 32'(count_next);

    thph_factor u_factor (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (fac_start),
        .weights        (weights_reg),
        .console_in_use (console_reg),
        .unique_users   (users_reg),
        .load_avg_1     (l1_reg),
        .load_avg_5     (l5_reg),
        .load_avg_15    (l15_reg),
        .done           (fac_done),
        .user_factor    (fac_uf),
        .load_factor    (fac_lf)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        count_next      = count_reg;
        mine_next       = mine_reg;
        top_uf_next     = top_uf_reg;
        at_next         = at_reg;
        p_next          = p_reg;
        c_next          = c_reg;
        got_next        = got_reg;
        carry_next      = carry_reg;
        left_next       = left_reg;
        have_last_next  = have_last_reg;
        ins_after_next  = ins_after_reg;
        bubble_ins_next = bubble_ins_reg;
        granted_next    = granted_reg;
        status_next     = status_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        hw_en           = 1'b0;
        hw_addr         = p_reg;
        hw_data         = hr_q;
        hr_addr         = PW'(1);
        pw_en           = 1'b0;
        pw_addr         = hr_q.host;
        pw_data         = p_reg;
        pr_addr         = in_host32[HB-1:0];
        fac_start       = 1'b0;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                pw_en   = 1'b1;
                pw_addr = clr_reg;
                pw_data = '0;
                clr_next = clr_reg + HB'(1);
                if (clr_reg == {HB{1'b1}})
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                // top entry and position of the named host are read at once
                if (accept)
                begin
                    status_next     = thph_pkg::STATUS_DONE;
                    granted_next    = 1'b0;
                    ins_after_next  = 1'b0;
                    bubble_ins_next = 1'b0;
                    state_next      = S_LOOK;
                end
            end
            S_LOOK:
            begin
                mine_next   = mine_c;
                top_uf_next = hr_q.uf;
                hr_addr     = mine_c;
                unique case (mode_reg)
                    thph_pkg::MODE_REPORT:
                    begin
                        fac_start  = 1'b1;
                        state_next = S_MUL;
                    end
                    thph_pkg::MODE_WITHDRAW:
                    begin
                        if (mine_c == '0)
                        begin
                            status_next = thph_pkg::STATUS_NONE;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            at_next    = mine_c;
                            state_next = S_RM0;
                        end
                    end
                    default:
                        state_next = S_CHK;
                endcase
            end
            S_CHK:
            begin
                if (at_c == '0 || at_c > AW'(count_reg))
                begin
                    status_next = thph_pkg::STATUS_NONE;
                    state_next  = S_FIN;
                end
                else
                begin
                    at_next      = at_c[PW-1:0];
                    granted_next = 1'b1;
                    state_next   = S_RM0;
                end
            end
            S_MUL:
            begin
                if (fac_done)
                begin
                    carry_next.host = host_reg;
                    carry_next.uf   = fac_uf;
                    carry_next.lf   = fac_lf;
                    if (mine_reg != '0)
                    begin
                        at_next        = mine_reg;
                        ins_after_next = 1'b1;
                        state_next     = S_RM0;
                    end
                    else
                        state_next = S_INS;
                end
            end
            S_RM0:
            begin
                hr_addr    = at_reg;
                count_next = count_reg - PW'(1);
                p_next     = at_reg;
                state_next = S_RM1;
            end
            S_RM1:
            begin
                got_next   = hr_q;
                hr_addr    = count_reg + PW'(1);
                state_next = S_RM2;
            end
            S_RM2:
            begin
                carry_next      = hr_q;
                have_last_next  = (count_reg != '0) && (at_reg <= count_reg);
                bubble_ins_next = 1'b0;
                state_next      = S_SD0;
            end
            S_SD0:
            begin
                // hole walks down to a leaf
                if (c_c > n_ext)
                    state_next = have_last_reg ? S_UP0 : S_RMEND;
                else
                begin
                    hr_addr    = c_c[PW-1:0];
                    c_next     = c_c;
                    state_next = S_SD1;
                end
            end
            S_SD1:
            begin
                left_next = hr_q;
                if (c_plus <= n_ext)
                begin
                    hr_addr    = c_plus[PW-1:0];
                    state_next = S_SD2;
                end
                else
                begin
                    hw_en      = 1'b1;
                    hw_data    = hr_q;
                    pw_en      = 1'b1;
                    pw_addr    = hr_q.host;
                    p_next     = c_reg[PW-1:0];
                    state_next = S_SD0;
                end
            end
            S_SD2:
            begin
                hw_en      = 1'b1;
                hw_data    = pick_left ? left_reg : hr_q;
                pw_en      = 1'b1;
                pw_addr    = pick_left ? left_reg.host : hr_q.host;
                p_next     = pick_left ? c_reg[PW-1:0] : c_plus[PW-1:0];
                state_next = S_SD0;
            end
            S_UP0:
            begin
                if (p_reg > PW'(1))
                begin
                    hr_addr    = p_reg >> 1;
                    state_next = S_UP1;
                end
                else
                begin
                    hw_en      = 1'b1;
                    hw_data    = carry_reg;
                    pw_en      = 1'b1;
                    pw_addr    = carry_reg.host;
                    state_next = bubble_ins_reg ? S_FIN : S_RMEND;
                end
            end
            S_UP1:
            begin
                hw_en = 1'b1;
                pw_en = 1'b1;
                if (thph_pkg::entry_le(hr_q.uf, hr_q.lf, carry_reg.uf, carry_reg.lf))
                begin
                    hw_data    = carry_reg;
                    pw_addr    = carry_reg.host;
                    state_next = bubble_ins_reg ? S_FIN : S_RMEND;
                end
                else
                begin
                    hw_data    = hr_q;
                    pw_addr    = hr_q.host;
                    p_next     = p_reg >> 1;
                    state_next = S_UP0;
                end
            end
            S_RMEND:
            begin
                pw_en      = 1'b1;
                pw_addr    = got_reg.host;
                pw_data    = '0;
                state_next = ins_after_reg ? S_INS : S_FIN;
            end
            S_INS:
            begin
                if (count_reg >= PW'(HEAP_DEPTH))
                begin
                    status_next = thph_pkg::STATUS_FULL;
                    state_next  = S_FIN;
                end
                else
                begin
                    count_next      = count_reg + PW'(1);
                    p_next          = count_reg + PW'(1);
                    carry_next.host = host_reg;
                    carry_next.uf   = fac_uf;
                    carry_next.lf   = fac_lf;
                    bubble_ins_next = 1'b1;
                    state_next      = S_UP0;
                end
            end
            S_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = '0;
                    if (granted_reg)
                    begin
                        m_tdata_next[9:0]   = got_host32[9:0];
                        m_tdata_next[26:10] = got_reg.uf;
                        m_tdata_next[52:27] = got_reg.lf;
                    end
                    m_tdata_next[61:53] = count32[8:0];
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            weights_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    thph_pkg::REG_CONSOLE_W: weights_reg.console_weight <= cfg_data;
                    thph_pkg::REG_TTY_W:     weights_reg.tty_weight     <= cfg_data;
                    thph_pkg::REG_LOAD_W1:   weights_reg.load_weight_1  <= cfg_data;
                    thph_pkg::REG_LOAD_W5:   weights_reg.load_weight_5  <= cfg_data;
                    thph_pkg::REG_LOAD_W15:  weights_reg.load_weight_15 <= cfg_data;
                    default:                 weights_reg <= weights_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= s_tuser;
            host_reg    <= in_host32[HB-1:0];
            console_reg <= s_tdata[10];
            users_reg   <= s_tdata[18:11];
            l1_reg      <= s_tdata[34:19];
            l5_reg      <= s_tdata[50:35];
            l15_reg     <= s_tdata[66:51];
            pos_in_reg  <= s_tdata[75:67];
        end
        mine_reg       <= mine_next;
        top_uf_reg     <= top_uf_next;
        at_reg         <= at_next;
        p_reg          <= p_next;
        c_reg          <= c_next;
        got_reg        <= got_next;
        carry_reg      <= carry_next;
        left_reg       <= left_next;
        have_last_reg  <= have_last_next;
        ins_after_reg  <= ins_after_next;
        bubble_ins_reg <= bubble_ins_next;
        granted_reg    <= granted_next;
        status_reg     <= status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    // heap entries, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (hw_en)
            heap_mem[hw_addr] <= hw_data;
        hr_q <= heap_mem[hr_addr];
    end

    // host position map
    always_ff @(posedge clk)
    begin
        if (pw_en)
            pos_mem[pw_addr] <= pw_data;
        pr_q <= pos_mem[pr_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= PW'(HEAP_DEPTH))
        else $error("heap count beyond depth");

    a_full_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != thph_pkg::STATUS_DONE) |-> (m_tdata[52:0] == '0))
        else $error("grant fields set on a failed transaction");

    a_child_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SD1) |-> (c_reg <= n_ext))
        else $error("sift-down child beyond heap end");

    a_ready_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_LOOK))
        else $error("accepted transaction not started");
`endif

endmodule
